// ===== rtl/gou_pkg.sv =====
package gou_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = 12;
    localparam int S_DATA_W   = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SUM_W      = 50;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS    = 3'd4;

    localparam logic [2:0] MODE_DESCENT  = 3'd0;
    localparam logic [2:0] MODE_MOMENTUM = 3'd1;
    localparam logic [2:0] MODE_ADAGRAD  = 3'd2;
    localparam logic [2:0] MODE_RMSPROP  = 3'd3;
    localparam logic [2:0] MODE_ADAM     = 3'd4;

    typedef enum logic [2:0] {
        K_NONE,
        K_DESCENT,
        K_MOMENTUM,
        K_ADAGRAD,
        K_RMSPROP,
        K_ADAM,
        K_LOOK_MOM,
        K_LOOK_ADAM
    } kind_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] step_size;
        logic [15:0] first_decay;
        logic [15:0] second_decay;
        logic [15:0] epsilon_term;
    } cfg_t;

    typedef struct packed {
        kind_t                    kind;
        logic [IDX_W-1:0]         param_index;
        logic signed [DATA_W-1:0] gradient;
    } item_t;

    function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] x);
        return x[DATA_W-1] ? (~x + 32'd1) : x;
    endfunction

    // shift right by 16 rounding half away from zero, then clip to 32 bits
    // returns {clipped, value}
    function automatic logic [DATA_W:0] rnd_sat(input logic [SUM_W-1:0] x);
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] r;
        logic [SUM_W-1:0] neg;
        mag = x[SUM_W-1] ? (~x + 50'd1) : x;
        r   = (mag + 50'd32768) >> 16;
        neg = 50'd0 - r;
        if (x[SUM_W-1])
        begin
            if (r > 50'h0_0000_8000_0000)
                return {1'b1, 32'h8000_0000};
            return {1'b0, neg[DATA_W-1:0]};
        end
        if (r > 50'h0_0000_7FFF_FFFF)
            return {1'b1, 32'h7FFF_FFFF};
        return {1'b0, r[DATA_W-1:0]};
    endfunction

    function automatic logic [DATA_W:0] neg_sat(input logic [DATA_W-1:0] x);
        if (x == 32'h8000_0000)
            return {1'b1, 32'h7FFF_FFFF};
        return {1'b0, 32'd0 - x};
    endfunction

endpackage

// ===== rtl/gou_front.sv =====
module gou_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gou_pkg::S_DATA_W-1:0]   s_tdata,   // param_index[11:0], gradient[43:12]
    input  logic [0:0]                     s_tuser,   // op
    input  logic [2:0]                     mode,
    input  logic                           clearing,
    output logic                           q_valid,
    output gou_pkg::item_t                 q_item,
    input  logic                           q_pop
);

    gou_pkg::item_t fifo_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push;
    gou_pkg::kind_t kind;

    always_comb
    begin
        kind = gou_pkg::K_NONE;
        if (s_tuser[0])
        begin
            case (mode)
                gou_pkg::MODE_MOMENTUM: kind = gou_pkg::K_LOOK_MOM;
                gou_pkg::MODE_ADAM:     kind = gou_pkg::K_LOOK_ADAM;
                default:                kind = gou_pkg::K_NONE;
            endcase
        end
        else
        begin
            case (mode)
                gou_pkg::MODE_DESCENT:  kind = gou_pkg::K_DESCENT;
                gou_pkg::MODE_MOMENTUM: kind = gou_pkg::K_MOMENTUM;
                gou_pkg::MODE_ADAGRAD:  kind = gou_pkg::K_ADAGRAD;
                gou_pkg::MODE_RMSPROP:  kind = gou_pkg::K_RMSPROP;
                gou_pkg::MODE_ADAM:     kind = gou_pkg::K_ADAM;
                default:                kind = gou_pkg::K_NONE;
            endcase
        end
    end

    assign s_tready = (cnt_reg != 2'd2) && !clearing;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = ~wr_ptr_reg;
        if (q_pop)
            rd_ptr_next = ~rd_ptr_reg;
        if (push && !q_pop)
            cnt_next = cnt_reg + 2'd1;
        else if (!push && q_pop)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg].kind        <= kind;
            fifo_reg[wr_ptr_reg].param_index <= s_tdata[11:0];
            fifo_reg[wr_ptr_reg].gradient    <= s_tdata[43:12];
        end
    end

endmodule

// ===== rtl/gou_back.sv =====
module gou_back
#(
    parameter int DEPTH = 4096
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  gou_pkg::cfg_t                cfg,
    input  logic                         q_valid,
    input  gou_pkg::item_t               q_item,
    output logic                         q_pop,
    output logic                         clearing,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [gou_pkg::DATA_W-1:0]   m_tdata,   // delta[31:0]
    output logic [0:0]                   m_tuser    // saturated
);

    localparam int  F        = gou_pkg::FRAC_BITS;
    localparam int  SW       = gou_pkg::SUM_W;
    localparam int  AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam bit  NEED_RED = (DEPTH < 4096);
    localparam int  RW       = 32 + F + 1;
    localparam int  NS       = (RW + 1) / 2;
    localparam int  SQ_CW    = $clog2(NS + 1);
    localparam int  QW       = 48;
    localparam int  DV_CYC   = QW / 2;
    localparam int  DV_CW    = $clog2(DV_CYC + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_RED, S_RD, S_LD, S_MA, S_LA, S_MB, S_MC, S_GSQ, S_G2,
        S_VB1, S_VB2, S_VB3, S_SQI, S_SQ, S_RA, S_DVI, S_DV, S_DF, S_OUT
    } state_t;

    logic [31:0] mem_m [DEPTH];
    logic [31:0] mem_v [DEPTH];
    logic [31:0] rdm_reg, rdv_reg;

    state_t            state_reg, state_next;
    logic              clr_busy_reg, clr_busy_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    gou_pkg::kind_t    kind_reg, kind_next;
    logic [31:0]       g_reg, g_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [11:0]       red_reg, red_next;
    logic [3:0]        red_cnt_reg, red_cnt_next;
    logic [31:0]       m_reg, m_next;
    logic [31:0]       v_reg, v_next;
    logic [63:0]       p_reg, p_next;
    logic              psign_reg, psign_next;
    logic [SW-1:0]     acc_reg, acc_next;
    logic [63:0]       bsum_reg, bsum_next;
    logic [31:0]       g2c_reg, g2c_next;
    logic [RW-1:0]     x_reg, x_next;
    logic [RW-1:0]     res_reg, res_next;
    logic [RW-1:0]     bit_reg, bit_next;
    logic [SQ_CW-1:0]  sq_cnt_reg, sq_cnt_next;
    logic              nsign_reg, nsign_next;
    logic              ovf_reg, ovf_next;
    logic [NS-1:0]     rem_reg, rem_next;
    logic [QW-1:0]     dlow_reg, dlow_next;
    logic [QW-1:0]     q_reg, q_next;
    logic [DV_CW-1:0]  dv_cnt_reg, dv_cnt_next;
    logic              flag_reg, flag_next;
    logic [31:0]       delta_reg, delta_next;
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       out_delta_reg, out_delta_next;
    logic              out_sat_reg, out_sat_next;

    logic [31:0]       mul_a, mul_b;
    logic              mul_sign;
    logic [SW-1:0]     p_sgn;
    logic [32:0]       mc_res;
    logic [32:0]       dn_w, la_w, ln_w, mn_w;
    logic [63:0]       g2_w, nv64, bs64, bs_r;
    logic [31:0]       nv_w, vb_w;
    logic              nv_ovf, vb_ovf, g2_ovf;
    logic [31:0]       rcmp;
    logic [11:0]       red_w;
    logic [31:0]       num_w;
    logic [QW-1:0]     a_w;
    logic [NS-1:0]     r_w;
    logic [NS-1:0]     rem_w;
    logic [QW-1:0]     dl_w, q_w;
    logic [NS:0]       dt;
    logic [RW-1:0]     sq_t;
    logic [48:0]       qr;
    logic [32:0]       out33;
    logic              m_we, v_we;
    logic [AW-1:0]     wa;
    logic [31:0]       m_wd, v_wd;

    assign clearing = clr_busy_reg;
    assign q_pop    = (state_reg == S_IDLE) && !clr_busy_reg && q_valid;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_delta_reg;
    assign m_tuser  = out_sat_reg;

    // shared datapath terms
    assign p_sgn  = psign_reg ? (50'd0 - {2'b00, p_reg[47:0]}) : {2'b00, p_reg[47:0]};
    assign mc_res = gou_pkg::rnd_sat(acc_reg + p_sgn);
    assign dn_w   = gou_pkg::rnd_sat(50'd0 - p_sgn);
    assign la_w   = gou_pkg::rnd_sat(p_sgn);
    assign ln_w   = gou_pkg::neg_sat(la_w[31:0]);
    assign mn_w   = gou_pkg::neg_sat(mc_res[31:0]);
    assign g2_w   = (p_reg + 64'(1 << (F - 1))) >> F;
    assign g2_ovf = (g2_w > 64'h0000_0000_FFFF_FFFF);
    assign nv64   = {32'd0, v_reg} + g2_w;
    assign nv_ovf = (nv64 > 64'h0000_0000_FFFF_FFFF);
    assign nv_w   = nv_ovf ? 32'hFFFF_FFFF : nv64[31:0];
    assign bs64   = bsum_reg + p_reg;
    assign bs_r   = (bs64 + 64'd32768) >> 16;
    assign vb_ovf = (bs_r > 64'h0000_0000_FFFF_FFFF);
    assign vb_w   = vb_ovf ? 32'hFFFF_FFFF : bs_r[31:0];
    assign rcmp   = 32'(DEPTH) << red_cnt_reg;
    assign red_w  = ({20'd0, red_reg} >= rcmp) ? (red_reg - rcmp[11:0]) : red_reg;
    assign num_w  = ((kind_reg == gou_pkg::K_ADAM) || (kind_reg == gou_pkg::K_LOOK_ADAM))
                    ? m_reg : g_reg;
    assign a_w    = p_reg[QW-1:0];
    assign r_w    = res_reg[NS-1:0];
    assign sq_t   = res_reg + bit_reg;
    assign qr     = {1'b0, q_reg} + 49'd32768;
    assign out33  = ovf_reg ? 33'h1_0000_0000 : qr[48:16];

    // two restoring quotient bits per cycle
    always_comb
    begin
        rem_w = rem_reg;
        dl_w  = dlow_reg;
        q_w   = q_reg;
        dt    = '0;
        for (int i = 0; i < 2; i++)
        begin
            dt = {rem_w, dl_w[QW-1]};
            if (dt >= {1'b0, r_w})
            begin
                dt  = dt - {1'b0, r_w};
                q_w = {q_w[QW-2:0], 1'b1};
            end
            else
            begin
                q_w = {q_w[QW-2:0], 1'b0};
            end
            rem_w = dt[NS-1:0];
            dl_w  = {dl_w[QW-2:0], 1'b0};
        end
    end

    always_comb
    begin
        mul_a    = 32'd0;
        mul_b    = 32'd0;
        mul_sign = 1'b0;
        case (state_reg)
            S_MA:
            begin
                if (kind_reg == gou_pkg::K_DESCENT)
                begin
                    mul_a    = {16'd0, cfg.step_size};
                    mul_b    = gou_pkg::mag32(g_reg);
                    mul_sign = g_reg[31];
                end
                else
                begin
                    mul_a    = {16'd0, cfg.first_decay};
                    mul_b    = gou_pkg::mag32(m_reg);
                    mul_sign = m_reg[31];
                end
            end
            S_MB:
            begin
                mul_a    = (kind_reg == gou_pkg::K_MOMENTUM) ? {16'd0, cfg.step_size}
                           : (32'h0001_0000 - {16'd0, cfg.first_decay});
                mul_b    = gou_pkg::mag32(g_reg);
                mul_sign = g_reg[31];
            end
            S_GSQ:
            begin
                mul_a = gou_pkg::mag32(g_reg);
                mul_b = gou_pkg::mag32(g_reg);
            end
            S_VB1:
            begin
                mul_a = {16'd0, cfg.second_decay};
                mul_b = v_reg;
            end
            S_VB2:
            begin
                mul_a = 32'h0001_0000 - {16'd0, cfg.second_decay};
                mul_b = g2c_reg;
            end
            S_RA:
            begin
                mul_a    = {16'd0, cfg.step_size};
                mul_b    = gou_pkg::mag32(num_w);
                mul_sign = num_w[31];
            end
            default:
            begin
                mul_a = 32'd0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_busy_next  = clr_busy_reg;
        clr_cnt_next   = clr_cnt_reg;
        kind_next      = kind_reg;
        g_next         = g_reg;
        addr_next      = addr_reg;
        red_next       = red_reg;
        red_cnt_next   = red_cnt_reg;
        m_next         = m_reg;
        v_next         = v_reg;
        p_next         = p_reg;
        psign_next     = psign_reg;
        acc_next       = acc_reg;
        bsum_next      = bsum_reg;
        g2c_next       = g2c_reg;
        x_next         = x_reg;
        res_next       = res_reg;
        bit_next       = bit_reg;
        sq_cnt_next    = sq_cnt_reg;
        nsign_next     = nsign_reg;
        ovf_next       = ovf_reg;
        rem_next       = rem_reg;
        dlow_next      = dlow_reg;
        q_next         = q_reg;
        dv_cnt_next    = dv_cnt_reg;
        flag_next      = flag_reg;
        delta_next     = delta_reg;
        out_valid_next = out_valid_reg;
        out_delta_next = out_delta_reg;
        out_sat_next   = out_sat_reg;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == LAST_ADDR)
                clr_busy_next = 1'b0;
        end

        if ((state_reg == S_MA) || (state_reg == S_MB) || (state_reg == S_GSQ) ||
            (state_reg == S_VB1) || (state_reg == S_VB2) || (state_reg == S_RA))
        begin
            p_next     = mul_a * mul_b;
            psign_next = mul_sign;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    kind_next  = q_item.kind;
                    g_next     = q_item.gradient;
                    flag_next  = 1'b0;
                    delta_next = 32'd0;
                    if (NEED_RED)
                    begin
                        red_next     = q_item.param_index;
                        red_cnt_next = 4'd11;
                        state_next   = S_RED;
                    end
                    else
                    begin
                        addr_next  = AW'(q_item.param_index);
                        state_next = S_RD;
                    end
                end
            end
            S_RED:
            begin
                red_next = red_w;
                if (red_cnt_reg == 4'd0)
                begin
                    addr_next  = AW'(red_w);
                    state_next = S_RD;
                end
                else
                begin
                    red_cnt_next = red_cnt_reg - 4'd1;
                end
            end
            S_RD:
            begin
                state_next = S_LD;
            end
            S_LD:
            begin
                m_next = rdm_reg;
                v_next = rdv_reg;
                case (kind_reg)
                    gou_pkg::K_DESCENT, gou_pkg::K_MOMENTUM, gou_pkg::K_ADAM,
                    gou_pkg::K_LOOK_MOM:
                        state_next = S_MA;
                    gou_pkg::K_ADAGRAD, gou_pkg::K_RMSPROP:
                        state_next = S_GSQ;
                    gou_pkg::K_LOOK_ADAM:
                        state_next = S_SQI;
                    default:
                        state_next = S_OUT;
                endcase
            end
            S_MA:
            begin
                if ((kind_reg == gou_pkg::K_DESCENT) || (kind_reg == gou_pkg::K_LOOK_MOM))
                    state_next = S_LA;
                else
                    state_next = S_MB;
            end
            S_LA:
            begin
                if (kind_reg == gou_pkg::K_DESCENT)
                begin
                    delta_next = dn_w[31:0];
                    flag_next  = flag_reg | dn_w[32];
                end
                else
                begin
                    delta_next = ln_w[31:0];
                    flag_next  = flag_reg | la_w[32] | ln_w[32];
                end
                state_next = S_OUT;
            end
            S_MB:
            begin
                acc_next   = p_sgn;
                state_next = S_MC;
            end
            S_MC:
            begin
                m_next    = mc_res[31:0];
                flag_next = flag_reg | mc_res[32];
                if (kind_reg == gou_pkg::K_MOMENTUM)
                begin
                    delta_next = mn_w[31:0];
                    flag_next  = flag_reg | mc_res[32] | mn_w[32];
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_GSQ;
                end
            end
            S_GSQ:
            begin
                state_next = S_G2;
            end
            S_G2:
            begin
                if (kind_reg == gou_pkg::K_ADAGRAD)
                begin
                    v_next     = nv_w;
                    flag_next  = flag_reg | nv_ovf;
                    state_next = S_SQI;
                end
                else
                begin
                    g2c_next   = g2_ovf ? 32'hFFFF_FFFF : g2_w[31:0];
                    flag_next  = flag_reg | g2_ovf;
                    state_next = S_VB1;
                end
            end
            S_VB1:
            begin
                state_next = S_VB2;
            end
            S_VB2:
            begin
                bsum_next  = p_reg;
                state_next = S_VB3;
            end
            S_VB3:
            begin
                v_next     = vb_w;
                flag_next  = flag_reg | vb_ovf;
                state_next = S_SQI;
            end
            S_SQI:
            begin
                x_next      = RW'({v_reg, {F{1'b0}}}) + (RW'(cfg.epsilon_term) << (2 * F - 16));
                res_next    = '0;
                bit_next    = RW'(1) << (2 * (NS - 1));
                sq_cnt_next = SQ_CW'(NS);
                state_next  = S_SQ;
            end
            S_SQ:
            begin
                if (x_reg >= sq_t)
                begin
                    x_next   = x_reg - sq_t;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next    = bit_reg >> 2;
                sq_cnt_next = sq_cnt_reg - 1'b1;
                if (sq_cnt_reg == SQ_CW'(1))
                    state_next = S_RA;
            end
            S_RA:
            begin
                nsign_next = num_w[31];
                if (res_reg == '0)
                begin
                    flag_next  = 1'b1;
                    delta_next = 32'd0;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_DVI;
                end
            end
            S_DVI:
            begin
                if (NS'(a_w[QW-1 -: F]) >= r_w)
                begin
                    ovf_next   = 1'b1;
                    state_next = S_DF;
                end
                else
                begin
                    ovf_next    = 1'b0;
                    rem_next    = NS'(a_w[QW-1 -: F]);
                    dlow_next   = {a_w[QW-F-1:0], {F{1'b0}}};
                    q_next      = '0;
                    dv_cnt_next = DV_CW'(DV_CYC);
                    state_next  = S_DV;
                end
            end
            S_DV:
            begin
                rem_next    = rem_w;
                dlow_next   = dl_w;
                q_next      = q_w;
                dv_cnt_next = dv_cnt_reg - 1'b1;
                if (dv_cnt_reg == DV_CW'(1))
                    state_next = S_DF;
            end
            S_DF:
            begin
                if (nsign_reg)
                begin
                    if (out33 > 33'h0_7FFF_FFFF)
                    begin
                        delta_next = 32'h7FFF_FFFF;
                        flag_next  = 1'b1;
                    end
                    else
                    begin
                        delta_next = out33[31:0];
                    end
                end
                else
                begin
                    if (out33 > 33'h0_8000_0000)
                    begin
                        delta_next = 32'h8000_0000;
                        flag_next  = 1'b1;
                    end
                    else
                    begin
                        delta_next = 32'd0 - out33[31:0];
                    end
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_delta_next = delta_reg;
                    out_sat_next   = flag_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            kind_reg      <= gou_pkg::K_NONE;
            g_reg         <= '0;
            addr_reg      <= '0;
            red_reg       <= '0;
            red_cnt_reg   <= '0;
            m_reg         <= '0;
            v_reg         <= '0;
            p_reg         <= '0;
            psign_reg     <= 1'b0;
            acc_reg       <= '0;
            bsum_reg      <= '0;
            g2c_reg       <= '0;
            x_reg         <= '0;
            res_reg       <= '0;
            bit_reg       <= '0;
            sq_cnt_reg    <= '0;
            nsign_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            rem_reg       <= '0;
            dlow_reg      <= '0;
            q_reg         <= '0;
            dv_cnt_reg    <= '0;
            flag_reg      <= 1'b0;
            delta_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_delta_reg <= '0;
            out_sat_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_busy_reg  <= clr_busy_next;
            clr_cnt_reg   <= clr_cnt_next;
            kind_reg      <= kind_next;
            g_reg         <= g_next;
            addr_reg      <= addr_next;
            red_reg       <= red_next;
            red_cnt_reg   <= red_cnt_next;
            m_reg         <= m_next;
            v_reg         <= v_next;
            p_reg         <= p_next;
            psign_reg     <= psign_next;
            acc_reg       <= acc_next;
            bsum_reg      <= bsum_next;
            g2c_reg       <= g2c_next;
            x_reg         <= x_next;
            res_reg       <= res_next;
            bit_reg       <= bit_next;
            sq_cnt_reg    <= sq_cnt_next;
            nsign_reg     <= nsign_next;
            ovf_reg       <= ovf_next;
            rem_reg       <= rem_next;
            dlow_reg      <= dlow_next;
            q_reg         <= q_next;
            dv_cnt_reg    <= dv_cnt_next;
            flag_reg      <= flag_next;
            delta_reg     <= delta_next;
            out_valid_reg <= out_valid_next;
            out_delta_reg <= out_delta_next;
            out_sat_reg   <= out_sat_next;
        end
    end

    // moment stores: zero sweep after reset, otherwise written back at the item's address
    assign m_we = clr_busy_reg || (state_reg == S_MC);
    assign v_we = clr_busy_reg || (state_reg == S_VB3) ||
                  ((state_reg == S_G2) && (kind_reg == gou_pkg::K_ADAGRAD));
    assign wa   = clr_busy_reg ? clr_cnt_reg : addr_reg;
    assign m_wd = clr_busy_reg ? 32'd0 : mc_res[31:0];
    assign v_wd = clr_busy_reg ? 32'd0 : ((state_reg == S_G2) ? nv_w : vb_w);

    always_ff @(posedge clk)
    begin
        if (m_we)
            mem_m[wa] <= m_wd;
        rdm_reg <= mem_m[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
            mem_v[wa] <= v_wd;
        rdv_reg <= mem_v[addr_reg];
    end

    a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !q_pop)
        else $error("item taken during clearing pass");

    a_root_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RA) |-> (res_reg >> NS) == '0)
        else $error("square root wider than divisor");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DV) |-> (rem_reg < r_w))
        else $error("partial remainder not below divisor");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("result register loaded outside result state");

endmodule

// ===== rtl/gradient_optimizer_update.sv =====
// Each item passes the input queue, an index reduction when DEPTH < 4096, a moment store read,
// the mode's multiply, square-root and quotient steps, and the result register; an unknown mode
// goes straight to the result. A zero root or a clipped quotient skips the quotient loop.
// Throughput: one item at a time in the execution unit, the next taken the cycle after a result
// loads; the square root and the quotient (two bits a cycle) set the ratio modes.
// Reset: registers take their defaults, then a pass over every address zeroes both moment stores.
module gradient_optimizer_update
#(
    parameter int DEPTH = 4096
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [gou_pkg::S_DATA_W-1:0]     s_tdata,   // param_index[11:0], gradient[43:12]
    input  logic [0:0]                       s_tuser,   // op
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [gou_pkg::DATA_W-1:0]       m_tdata,   // delta[31:0]
    output logic [0:0]                       m_tuser,   // saturated
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gou_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gou_pkg::CFG_DATA_W-1:0]   cfg_data
);

    gou_pkg::cfg_t  cfg_reg, cfg_next;
    logic           q_valid;
    gou_pkg::item_t q_item;
    logic           q_pop;
    logic           clearing;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                gou_pkg::CFG_MODE:   cfg_next.mode         = cfg_data[2:0];
                gou_pkg::CFG_STEP:   cfg_next.step_size    = cfg_data;
                gou_pkg::CFG_FIRST:  cfg_next.first_decay  = cfg_data;
                gou_pkg::CFG_SECOND: cfg_next.second_decay = cfg_data;
                gou_pkg::CFG_EPS:    cfg_next.epsilon_term = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode         <= gou_pkg::MODE_DESCENT;
            cfg_reg.step_size    <= 16'd655;
            cfg_reg.first_decay  <= 16'd0;
            cfg_reg.second_decay <= 16'd0;
            cfg_reg.epsilon_term <= 16'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gou_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .mode     (cfg_reg.mode),
        .clearing (clearing),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    gou_back #(.DEPTH(DEPTH)) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
